// ===== src/lfmd_pkg.sv =====
// Shared types, reset constants and the steering decision table for the
// line follower motor drive. No dependencies.
package lfmd_pkg;

   localparam int DUTY_W = 8;
   localparam int CSR_IDX_W = 3;

   localparam logic [DUTY_W-1:0] RST_PWM_PERIOD  = 8'd125;
   localparam logic [DUTY_W-1:0] RST_FULL_DUTY   = 8'd124;
   localparam logic [DUTY_W-1:0] RST_TURN_DUTY   = 8'd100;
   localparam logic [DUTY_W-1:0] RST_CRUISE_DUTY = 8'd62;
   localparam logic [DUTY_W-1:0] RST_SLOW_DUTY   = 8'd40;
   localparam logic [DUTY_W-1:0] RST_WHEEL_DUTY  = 8'd62;

   typedef enum logic [1:0] {
      DIR_STOP = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_REV  = 2'd2
   } dir_type;

   typedef enum logic [1:0] {
      SPIN_NONE  = 2'd0,
      SPIN_LEFT  = 2'd1,
      SPIN_RIGHT = 2'd2
   } spin_type;

   typedef enum logic [2:0] {
      DSEL_KEEP   = 3'd0,
      DSEL_FULL   = 3'd1,
      DSEL_TURN   = 3'd2,
      DSEL_CRUISE = 3'd3,
      DSEL_SLOW   = 3'd4,
      DSEL_ZERO   = 3'd5
   } dsel_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PWM_PERIOD  = 3'd0,
      CSR_FULL_DUTY   = 3'd1,
      CSR_TURN_DUTY   = 3'd2,
      CSR_CRUISE_DUTY = 3'd3,
      CSR_SLOW_DUTY   = 3'd4
   } csr_idx_type;

   typedef struct packed {
      logic sense_far_left;
      logic sense_left;
      logic sense_right;
      logic sense_far_right;
      logic sense_center;
   } req_payload_type;

   typedef struct packed {
      logic       left_enable;
      logic       left_fwd_pin;
      logic       left_rev_pin;
      logic       right_enable;
      logic       right_fwd_pin;
      logic       right_rev_pin;
      logic [1:0] spin_mode;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [DUTY_W-1:0]    data;
   } csr_payload_type;

   typedef struct packed {
      logic [DUTY_W-1:0] pwm_period;
      logic [DUTY_W-1:0] full_duty;
      logic [DUTY_W-1:0] turn_duty;
      logic [DUTY_W-1:0] cruise_duty;
      logic [DUTY_W-1:0] slow_duty;
   } cfg_type;

   // one beat handed from the input register to the drive core
   typedef struct packed {
      logic            fire;
      req_payload_type sample;
   } step_type;

   typedef struct packed {
      dir_type  ldir;
      dir_type  rdir;
      dsel_type lsel;
      dsel_type rsel;
      spin_type spin;
   } rule_type;

   // index = far_left, left, center, right, far_right (msb first)
   function automatic rule_type rule_lookup(input logic [4:0] idx);
      rule_type r;
      case (idx)
         5'b00000: r = '{DIR_FWD,  DIR_FWD,  DSEL_SLOW,   DSEL_SLOW,   SPIN_NONE};
         5'b00001: r = '{DIR_FWD,  DIR_FWD,  DSEL_FULL,   DSEL_TURN,   SPIN_NONE};
         5'b00010: r = '{DIR_FWD,  DIR_FWD,  DSEL_TURN,   DSEL_ZERO,   SPIN_NONE};
         5'b00011: r = '{DIR_FWD,  DIR_REV,  DSEL_FULL,   DSEL_TURN,   SPIN_RIGHT};
         5'b00100: r = '{DIR_FWD,  DIR_FWD,  DSEL_FULL,   DSEL_FULL,   SPIN_NONE};
         5'b00101: r = '{DIR_FWD,  DIR_FWD,  DSEL_FULL,   DSEL_FULL,   SPIN_NONE};
         5'b00110: r = '{DIR_FWD,  DIR_FWD,  DSEL_FULL,   DSEL_TURN,   SPIN_NONE};
         5'b00111: r = '{DIR_FWD,  DIR_FWD,  DSEL_FULL,   DSEL_FULL,   SPIN_NONE};
         5'b01000: r = '{DIR_FWD,  DIR_FWD,  DSEL_ZERO,   DSEL_TURN,   SPIN_NONE};
         5'b01001: r = '{DIR_FWD,  DIR_REV,  DSEL_FULL,   DSEL_TURN,   SPIN_RIGHT};
         5'b01010: r = '{DIR_FWD,  DIR_FWD,  DSEL_SLOW,   DSEL_SLOW,   SPIN_NONE};
         5'b01011: r = '{DIR_FWD,  DIR_REV,  DSEL_FULL,   DSEL_TURN,   SPIN_RIGHT};
         5'b01100: r = '{DIR_FWD,  DIR_FWD,  DSEL_TURN,   DSEL_FULL,   SPIN_NONE};
         5'b01101: r = '{DIR_FWD,  DIR_FWD,  DSEL_TURN,   DSEL_FULL,   SPIN_NONE};
         5'b01110: r = '{DIR_FWD,  DIR_FWD,  DSEL_CRUISE, DSEL_CRUISE, SPIN_NONE};
         5'b01111: r = '{DIR_FWD,  DIR_FWD,  DSEL_TURN,   DSEL_FULL,   SPIN_NONE};
         5'b10000: r = '{DIR_FWD,  DIR_FWD,  DSEL_TURN,   DSEL_FULL,   SPIN_NONE};
         5'b10001: r = '{DIR_FWD,  DIR_REV,  DSEL_FULL,   DSEL_FULL,   SPIN_RIGHT};
         5'b10010: r = '{DIR_REV,  DIR_FWD,  DSEL_TURN,   DSEL_FULL,   SPIN_LEFT};
         5'b10011: r = '{DIR_STOP, DIR_STOP, DSEL_KEEP,   DSEL_KEEP,   SPIN_NONE};
         5'b10100: r = '{DIR_FWD,  DIR_FWD,  DSEL_FULL,   DSEL_FULL,   SPIN_NONE};
         5'b10101: r = '{DIR_STOP, DIR_STOP, DSEL_KEEP,   DSEL_KEEP,   SPIN_NONE};
         5'b10110: r = '{DIR_FWD,  DIR_FWD,  DSEL_FULL,   DSEL_TURN,   SPIN_NONE};
         5'b10111: r = '{DIR_STOP, DIR_STOP, DSEL_KEEP,   DSEL_KEEP,   SPIN_NONE};
         5'b11000: r = '{DIR_REV,  DIR_FWD,  DSEL_TURN,   DSEL_FULL,   SPIN_LEFT};
         5'b11001: r = '{DIR_STOP, DIR_STOP, DSEL_KEEP,   DSEL_KEEP,   SPIN_NONE};
         5'b11010: r = '{DIR_REV,  DIR_FWD,  DSEL_TURN,   DSEL_FULL,   SPIN_LEFT};
         5'b11011: r = '{DIR_STOP, DIR_STOP, DSEL_KEEP,   DSEL_KEEP,   SPIN_NONE};
         5'b11100: r = '{DIR_FWD,  DIR_FWD,  DSEL_FULL,   DSEL_FULL,   SPIN_NONE};
         5'b11101: r = '{DIR_STOP, DIR_STOP, DSEL_KEEP,   DSEL_KEEP,   SPIN_NONE};
         5'b11110: r = '{DIR_FWD,  DIR_FWD,  DSEL_FULL,   DSEL_TURN,   SPIN_NONE};
         5'b11111: r = '{DIR_FWD,  DIR_FWD,  DSEL_FULL,   DSEL_FULL,   SPIN_NONE};
         default:  r = '{DIR_STOP, DIR_STOP, DSEL_KEEP,   DSEL_KEEP,   SPIN_NONE};
      endcase
      return r;
   endfunction

endpackage

// ===== src/lfmd_chan_if.sv =====
// Valid/ready channel carrying one payload beat, used for the sensor,
// result and register write channels. Payload types come from lfmd_pkg.
interface lfmd_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== src/line_follower_motor_drive.sv =====
// Line follower motor drive, top level: input register, drive core, result register.
// The input register holds each sensor beat; the result register holds its result.
// Throughput: one beat per cycle unless stalled; the core state is the only loop.
// Backpressure on the result channel stalls both register stages together.
// Reset (synchronous, active high) empties both stages and restores registers and state.
// Depends on lfmd_pkg, lfmd_chan_if, lfmd_csr and lfmd_core.
module line_follower_motor_drive (
   input  logic        clock,
   input  logic        reset,
   lfmd_chan_if.sink   req_bus,
   lfmd_chan_if.source rsp_bus,
   lfmd_chan_if.sink   csr_bus
);
   lfmd_pkg::cfg_type         cfg;
   lfmd_pkg::step_type        step;
   lfmd_pkg::rsp_payload_type core_rsp;

   // input stage
   logic                      in_valid_ff;
   lfmd_pkg::req_payload_type in_data_ff;
   // result stage
   logic                      out_valid_ff;
   lfmd_pkg::rsp_payload_type out_data_ff;

   logic advance;

   // Pipeline moves whenever the result slot is free or being drained.
   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff  <= req_bus.valid;
         out_valid_ff <= in_valid_ff;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         in_data_ff  <= req_bus.data;
         out_data_ff <= core_rsp;
      end
   end

   // the core commits its state only when the held beat moves to the result slot
   assign step.fire   = advance && in_valid_ff;
   assign step.sample = in_data_ff;

   lfmd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   lfmd_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .step  (step),
      .rsp   (core_rsp)
   );

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.data  = out_data_ff;
endmodule

// ===== src/lfmd_csr.sv =====
// Register file for the PWM period and duty levels.
// Depends on lfmd_pkg and lfmd_chan_if.
module lfmd_csr (
   input  logic                clock,
   input  logic                reset,
   lfmd_chan_if.sink           csr_bus,
   output lfmd_pkg::cfg_type   cfg
);
   lfmd_pkg::cfg_type cfg_ff;
   lfmd_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (lfmd_pkg::csr_idx_type'(csr_bus.data.index))
            lfmd_pkg::CSR_PWM_PERIOD:  cfg_in.pwm_period  = csr_bus.data.data;
            lfmd_pkg::CSR_FULL_DUTY:   cfg_in.full_duty   = csr_bus.data.data;
            lfmd_pkg::CSR_TURN_DUTY:   cfg_in.turn_duty   = csr_bus.data.data;
            lfmd_pkg::CSR_CRUISE_DUTY: cfg_in.cruise_duty = csr_bus.data.data;
            lfmd_pkg::CSR_SLOW_DUTY:   cfg_in.slow_duty   = csr_bus.data.data;
            default:                   cfg_in = cfg_ff;  // unmapped index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pwm_period  <= lfmd_pkg::RST_PWM_PERIOD;
         cfg_ff.full_duty   <= lfmd_pkg::RST_FULL_DUTY;
         cfg_ff.turn_duty   <= lfmd_pkg::RST_TURN_DUTY;
         cfg_ff.cruise_duty <= lfmd_pkg::RST_CRUISE_DUTY;
         cfg_ff.slow_duty   <= lfmd_pkg::RST_SLOW_DUTY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

// ===== src/lfmd_core.sv =====
// Steering state, spin latch and PWM counter; builds one result per beat.
// Depends on lfmd_pkg (types, decision table).
module lfmd_core (
   input  logic                      clock,
   input  logic                      reset,
   input  lfmd_pkg::cfg_type         cfg,
   input  lfmd_pkg::step_type        step,
   output lfmd_pkg::rsp_payload_type rsp
);
   localparam int W = lfmd_pkg::DUTY_W;

   logic [W-1:0]       count_ff,  count_in;
   logic [W-1:0]       lduty_ff,  lduty_in;
   logic [W-1:0]       rduty_ff,  rduty_in;
   lfmd_pkg::dir_type  ldir_ff,   ldir_in;
   lfmd_pkg::dir_type  rdir_ff,   rdir_in;
   lfmd_pkg::spin_type spin_ff,   spin_in;

   lfmd_pkg::rule_type rule;
   logic               hold;
   logic [W-1:0]       lim;
   logic [W:0]         count_inc;

   function automatic logic [W-1:0] clamp(input logic [W-1:0] d, input logic [W-1:0] l);
      return (d > l) ? l : d;
   endfunction

   function automatic logic [W-1:0] pick(input lfmd_pkg::dsel_type sel,
                                         input logic [W-1:0] cur,
                                         input lfmd_pkg::cfg_type c,
                                         input logic [W-1:0] l);
      logic [W-1:0] d;
      case (sel)
         lfmd_pkg::DSEL_FULL:   d = clamp(c.full_duty, l);
         lfmd_pkg::DSEL_TURN:   d = clamp(c.turn_duty, l);
         lfmd_pkg::DSEL_CRUISE: d = clamp(c.cruise_duty, l);
         lfmd_pkg::DSEL_SLOW:   d = clamp(c.slow_duty, l);
         lfmd_pkg::DSEL_ZERO:   d = '0;
         default:               d = cur;
      endcase
      return d;
   endfunction

   assign rule = lfmd_pkg::rule_lookup({step.sample.sense_far_left, step.sample.sense_left,
                                        step.sample.sense_center, step.sample.sense_right,
                                        step.sample.sense_far_right});
   // latched spin ignores the sensors until the center one sees the line
   assign hold = (spin_ff != lfmd_pkg::SPIN_NONE) && !step.sample.sense_center;
   assign lim  = (cfg.pwm_period == '0) ? '0 : cfg.pwm_period - 1'b1;
   assign count_inc = {1'b0, count_ff} + 1'b1;

   always_comb begin
      ldir_in  = ldir_ff;
      rdir_in  = rdir_ff;
      lduty_in = lduty_ff;
      rduty_in = rduty_ff;
      spin_in  = spin_ff;
      if (!hold) begin
         ldir_in  = rule.ldir;
         rdir_in  = rule.rdir;
         lduty_in = pick(rule.lsel, lduty_ff, cfg, lim);
         rduty_in = pick(rule.rsel, rduty_ff, cfg, lim);
         spin_in  = rule.spin;
      end
      count_in = (count_inc >= {1'b0, cfg.pwm_period}) ? '0 : count_inc[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         lduty_ff <= lfmd_pkg::RST_WHEEL_DUTY;
         rduty_ff <= lfmd_pkg::RST_WHEEL_DUTY;
         ldir_ff  <= lfmd_pkg::DIR_FWD;
         rdir_ff  <= lfmd_pkg::DIR_FWD;
         spin_ff  <= lfmd_pkg::SPIN_NONE;
      end else if (step.fire) begin
         count_ff <= count_in;
         lduty_ff <= lduty_in;
         rduty_ff <= rduty_in;
         ldir_ff  <= ldir_in;
         rdir_ff  <= rdir_in;
         spin_ff  <= spin_in;
      end
   end

   always_comb begin
      rsp.left_enable   = count_in < lduty_in;
      rsp.left_fwd_pin  = ldir_in == lfmd_pkg::DIR_FWD;
      rsp.left_rev_pin  = ldir_in == lfmd_pkg::DIR_REV;
      rsp.right_enable  = count_in < rduty_in;
      rsp.right_fwd_pin = rdir_in == lfmd_pkg::DIR_FWD;
      rsp.right_rev_pin = rdir_in == lfmd_pkg::DIR_REV;
      rsp.spin_mode     = spin_in;
   end

   // counter wraps inside the period
   a_count_wrap: assert property (@(posedge clock) disable iff (reset)
      step.fire |=> (count_ff == '0) || (count_ff < $past(cfg.pwm_period)))
      else $error("period counter left its range");

   // a held spin leaves steering untouched
   a_spin_hold: assert property (@(posedge clock) disable iff (reset)
      step.fire && hold |=> (ldir_ff == $past(ldir_ff)) && (rdir_ff == $past(rdir_ff))
         && (lduty_ff == $past(lduty_ff)) && (rduty_ff == $past(rduty_ff))
         && (spin_ff == $past(spin_ff)))
      else $error("steering changed while spin held");

   // stop patterns keep both duties
   a_stop_keep: assert property (@(posedge clock) disable iff (reset)
      step.fire && !hold && (rule.ldir == lfmd_pkg::DIR_STOP)
         |=> (lduty_ff == $past(lduty_ff)) && (rduty_ff == $past(rduty_ff)))
      else $error("duty changed on stop pattern");
endmodule
